// ===== hw/rtl/lzfu_pkg.sv =====
// Shared constants, types and the RTF preamble table for the LZFu decoder.
package lzfu_pkg;

  localparam int DICT_DEPTH = 4096;
  localparam int IDX_W      = $clog2(DICT_DEPTH);
  localparam int FILL_W     = IDX_W + 1;
  localparam int PRE_LEN    = 207;

  // Result status codes
  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_END     = 2'd1;
  localparam logic [1:0] ST_RAN_OUT = 2'd2;
  localparam logic [1:0] ST_OVER    = 2'd3;

  // Fixed dictionary preamble, first character in the top bits
  localparam logic [PRE_LEN*8-1:0] PREAMBLE =
    {"{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}{\\f0\\fnil \\froman \\fswiss ",
     "\\fmodern \\fscript \\fdecor MS Sans SerifSymbolArialTimes New RomanCourier",
     "{\\colortbl\\red0\\green0\\blue0\015\n\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"};

  // Dictionary access request from the parser
  typedef struct packed {
    logic             restart;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } dict_req_t;

  // Value of a dictionary entry right after restart
  function automatic logic [7:0] preamble_byte(input logic [IDX_W-1:0] addr);
    int unsigned sh;
    logic [7:0]  b;
    sh = 0;
    b  = 8'd0;
    if (int'(addr) < PRE_LEN) begin
      sh = 8 * (PRE_LEN - 1 - int'(addr));
      b  = PREAMBLE[sh +: 8];
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/lzfu_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
module lzfu_ram #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/lzfu_dict.sv =====
// Circular dictionary: RAM plus fill count overlay for the preamble and write forwarding.
module lzfu_dict
  import lzfu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dict_req_t req,
  output logic [7:0] rd_data
);

  logic [FILL_W-1:0] fill_r, fill_nxt, fill_base;
  logic [IDX_W-1:0]  rel;
  logic              written;
  logic              fwd_r;
  logic [7:0]        fwd_data_r;
  logic              valid_r;
  logic [7:0]        pre_r;
  logic [7:0]        ram_q;

  lzfu_ram #(.AW(IDX_W), .DW(8)) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (ram_q)
  );

  // Entries written since restart form one run starting at the preamble end
  assign rel     = req.raddr - IDX_W'(PRE_LEN);
  assign written = ({1'b0, rel} < fill_r);

  always_comb begin
    fill_base = req.restart ? '0 : fill_r;
    fill_nxt  = fill_base;
    if (req.we && (fill_base != FILL_W'(DICT_DEPTH))) begin
      fill_nxt = fill_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      fwd_r      <= req.we && (req.waddr == req.raddr);
      fwd_data_r <= req.wdata;
      valid_r    <= written;
      pre_r      <= preamble_byte(req.raddr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : (valid_r ? ram_q : pre_r);

endmodule

// ===== hw/rtl/compressed_rtf_lz_decoder_core.sv =====
// A literal or status word passes from the pending registers, in S_EMIT, into the output register;
// a reference reads its first byte from the dictionary in S_COPY_RD, then copies one byte per cycle
// in S_COPY while the output register is free. A new input byte is taken only in S_IDLE, so a
// literal, status word or reference must be fully emitted before the next byte is accepted.
// Reset: synchronous active-low rst_n; the dictionary needs no clearing pass, a fill
// count makes unwritten entries read as the preamble or zero.
module compressed_rtf_lz_decoder_core
  import lzfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] compressed_byte
  input  logic        in_tuser,   // [0] start_of_message
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // output_limit
);

  typedef enum logic [1:0] {S_IDLE, S_EMIT, S_COPY_RD, S_COPY} state_t;
  typedef enum logic [1:0] {PH_CONTROL, PH_LITERAL, PH_REF_HIGH, PH_REF_LOW} phase_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt, phase_e, nf_phase;
  logic [7:0]       ctrl_r, ctrl_nxt;
  logic [2:0]       bit_r, bit_nxt, nf_bit;
  logic [7:0]       hi_r, hi_nxt;
  logic [IDX_W-1:0] wp_r, wp_nxt, wp_e;
  logic [31:0]      count_r, count_nxt, count_e;
  logic             ended_r, ended_nxt, ended_e;
  logic [31:0]      limit_r;
  logic [IDX_W-1:0] src_r, src_nxt, ref_src;
  logic [4:0]       len_r, len_nxt, ref_len;
  logic             final_r, final_nxt;
  logic [7:0]       pend_byte_r, pend_byte_nxt;
  logic [1:0]       pend_stat_r, pend_stat_nxt;
  logic             pend_last_r, pend_last_nxt;
  logic             follow_r, follow_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [1:0]       out_stat_r, out_stat_nxt;
  logic             out_last_r, out_last_nxt;
  logic             in_fire, out_free;
  logic             ref_over;
  dict_req_t        dreq;
  logic [7:0]       dict_q;

  lzfu_dict u_dict (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dreq),
    .rd_data (dict_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  // Effective state once a start flag has restarted the decoder
  assign phase_e = in_tuser ? PH_CONTROL : phase_r;
  assign ended_e = in_tuser ? 1'b0 : ended_r;
  assign count_e = in_tuser ? '0 : count_r;
  assign wp_e    = in_tuser ? IDX_W'(PRE_LEN) : wp_r;

  assign ref_src  = {hi_r, in_tdata[7:4]};
  assign ref_len  = {1'b0, in_tdata[3:0]} + 5'd2;
  assign ref_over = ({1'b0, count_e} + 33'(ref_len)) > {1'b0, limit_r};

  // Advance to the next flag of the control byte
  assign nf_bit   = bit_r + 3'd1;
  assign nf_phase = (bit_r == 3'd7) ? PH_CONTROL : (ctrl_r[nf_bit] ? PH_REF_HIGH : PH_LITERAL);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    ctrl_nxt      = ctrl_r;
    bit_nxt       = bit_r;
    hi_nxt        = hi_r;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    ended_nxt     = ended_r;
    src_nxt       = src_r;
    len_nxt       = len_r;
    final_nxt     = final_r;
    pend_byte_nxt = pend_byte_r;
    pend_stat_nxt = pend_stat_r;
    pend_last_nxt = pend_last_r;
    follow_nxt    = follow_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;
    dreq          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          dreq.restart  = in_tuser;
          phase_nxt     = phase_e;
          ended_nxt     = ended_e;
          count_nxt     = count_e;
          wp_nxt        = wp_e;
          final_nxt     = in_tlast;
          pend_byte_nxt = '0;
          pend_stat_nxt = ST_RAN_OUT;
          pend_last_nxt = 1'b1;
          follow_nxt    = 1'b0;
          if (!ended_e) begin
            if (in_tlast) begin
              ended_nxt = 1'b1;
              state_nxt = S_EMIT;
            end
            unique case (phase_e)
              PH_CONTROL: begin
                ctrl_nxt  = in_tdata;
                bit_nxt   = '0;
                phase_nxt = in_tdata[0] ? PH_REF_HIGH : PH_LITERAL;
              end
              PH_LITERAL: begin
                state_nxt = S_EMIT;
                if (count_e >= limit_r) begin
                  pend_stat_nxt = ST_OVER;
                  ended_nxt     = 1'b1;
                end else begin
                  dreq.we       = 1'b1;
                  dreq.waddr    = wp_e;
                  dreq.wdata    = in_tdata;
                  wp_nxt        = wp_e + 1'b1;
                  count_nxt     = count_e + 1'b1;
                  phase_nxt     = nf_phase;
                  bit_nxt       = nf_bit;
                  pend_byte_nxt = in_tdata;
                  pend_stat_nxt = ST_DATA;
                  pend_last_nxt = !in_tlast;
                  follow_nxt    = in_tlast;
                end
              end
              PH_REF_HIGH: begin
                hi_nxt    = in_tdata;
                phase_nxt = PH_REF_LOW;
              end
              PH_REF_LOW: begin
                if (ref_src == wp_e) begin
                  pend_stat_nxt = ST_END;
                  ended_nxt     = 1'b1;
                  state_nxt     = S_EMIT;
                end else if (ref_over) begin
                  pend_stat_nxt = ST_OVER;
                  ended_nxt     = 1'b1;
                  state_nxt     = S_EMIT;
                end else begin
                  src_nxt   = ref_src;
                  len_nxt   = ref_len;
                  state_nxt = S_COPY_RD;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pend_byte_r;
          out_stat_nxt  = pend_stat_r;
          out_last_nxt  = pend_last_r;
          if (follow_r) begin
            pend_byte_nxt = '0;
            pend_stat_nxt = ST_RAN_OUT;
            pend_last_nxt = 1'b1;
            follow_nxt    = 1'b0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_COPY_RD: begin
        dreq.re    = 1'b1;
        dreq.raddr = src_r;
        src_nxt    = src_r + 1'b1;
        state_nxt  = S_COPY;
      end
      S_COPY: begin
        // hold the read word until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = dict_q;
          out_stat_nxt  = ST_DATA;
          out_last_nxt  = (len_r == 5'd1) && !final_r;
          dreq.we       = 1'b1;
          dreq.waddr    = wp_r;
          dreq.wdata    = dict_q;
          wp_nxt        = wp_r + 1'b1;
          count_nxt     = count_r + 1'b1;
          len_nxt       = len_r - 5'd1;
          if (len_r != 5'd1) begin
            dreq.re    = 1'b1;
            dreq.raddr = src_r;
            src_nxt    = src_r + 1'b1;
          end else begin
            phase_nxt = nf_phase;
            bit_nxt   = nf_bit;
            if (final_r) begin
              pend_byte_nxt = '0;
              pend_stat_nxt = ST_RAN_OUT;
              pend_last_nxt = 1'b1;
              follow_nxt    = 1'b0;
              state_nxt     = S_EMIT;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_CONTROL;
      bit_r       <= '0;
      wp_r        <= IDX_W'(PRE_LEN);
      count_r     <= '0;
      ended_r     <= 1'b0;
      limit_r     <= '1;
      follow_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      ended_r     <= ended_nxt;
      follow_r    <= follow_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ctrl_r      <= ctrl_nxt;
    hi_r        <= hi_nxt;
    src_r       <= src_nxt;
    len_r       <= len_nxt;
    final_r     <= final_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_stat_r <= pend_stat_nxt;
    pend_last_r <= pend_last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_stat_r  <= out_stat_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stat_r != ST_DATA) |-> out_last_r && (out_byte_r == 8'd0))
    else $error("status word not marked last or carries data");

  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) || (state_r == S_COPY_RD) |-> (len_r != 5'd0))
    else $error("copy running with zero length");

  a_ended_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ended_r && !in_tuser |=> (state_r == S_IDLE))
    else $error("item after end produced work");

  a_copy_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) && out_free && (len_r == 5'd1) && !final_r |=>
      (state_r == S_IDLE) && out_valid_r && out_last_r)
    else $error("reference end not closed with last word");

endmodule

// ===== test/lzfu_stream_checker.sv =====
// Stream checker for the compressed RTF decoder: predicts every result word and compares.
`timescale 1ns / 1ps

module lzfu_stream_checker
  import lzfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] compressed_byte
  input  logic        in_tuser,   // [0] start_of_message
  input  logic        in_tlast,   // final_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] out_byte
  input  logic [1:0]  out_tuser,  // [1:0] status
  input  logic        out_tlast,  // last
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          pending
);

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_LIT,
    PH_OFS_HI,
    PH_OFS_LO
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } lz_word_t;

  string rtf_head = {
    "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}{\\f0\\fnil \\froman \\fswiss ",
    "\\fmodern \\fscript \\fdecor MS Sans SerifSymbolArialTimes New RomanCourier",
    "{\\colortbl\\red0\\green0\\blue0\015\n\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"};

  logic [7:0]   dict [0:DICT_DEPTH-1];
  logic [11:0]  wpos;
  parse_phase_t phase;
  logic [7:0]   ctrl;
  logic [3:0]   bit_no;
  logic [7:0]   ofs_hi;
  logic [31:0]  produced;
  logic [31:0]  limit;
  logic         ended;
  int           err_count;

  lz_word_t step_words [$];
  lz_word_t expected_words [$];

  task automatic restart_decoder();
    for (int i = 0; i < DICT_DEPTH; i++) begin
      dict[i] = (i < PRE_LEN) ? rtf_head[i] : 8'h00;
    end
    wpos     = 12'(PRE_LEN);
    phase    = PH_CTRL;
    ctrl     = 8'h00;
    bit_no   = 4'd0;
    ofs_hi   = 8'h00;
    produced = 32'd0;
    ended    = 1'b0;
  endtask

  // Append one word to the words of the current step.
  task automatic queue_word(input lz_word_t w);
    step_words = {step_words, w};
  endtask

  task automatic put_byte(input logic [7:0] b);
    queue_word('{b, ST_DATA, 1'b0});
    dict[wpos] = b;
    wpos       = wpos + 12'd1;
    produced   = produced + 32'd1;
  endtask

  task automatic advance_flag();
    bit_no = bit_no + 4'd1;
    if (bit_no >= 4'd8) begin
      bit_no = 4'd0;
      phase  = PH_CTRL;
    end else begin
      phase = ctrl[bit_no[2:0]] ? PH_OFS_HI : PH_LIT;
    end
  endtask

  // Work out the result words one compressed byte causes.
  task automatic decode_byte(input logic [7:0] b, input logic sos, input logic fin);
    logic [11:0] src;
    logic [4:0]  len;
    step_words.delete();
    if (sos) restart_decoder();
    if (ended) return;
    case (phase)
      PH_CTRL: begin
        ctrl   = b;
        bit_no = 4'd0;
        phase  = b[0] ? PH_OFS_HI : PH_LIT;
      end
      PH_LIT: begin
        if ({1'b0, produced} + 33'd1 > {1'b0, limit}) begin
          queue_word('{8'h00, ST_OVER, 1'b0});
          ended = 1'b1;
        end else begin
          put_byte(b);
          advance_flag();
        end
      end
      PH_OFS_HI: begin
        ofs_hi = b;
        phase  = PH_OFS_LO;
      end
      default: begin
        src = {ofs_hi, b[7:4]};
        len = {1'b0, b[3:0]} + 5'd2;
        if (src == wpos) begin
          queue_word('{8'h00, ST_END, 1'b0});
          ended = 1'b1;
        end else if ({1'b0, produced} + 33'(len) > {1'b0, limit}) begin
          queue_word('{8'h00, ST_OVER, 1'b0});
          ended = 1'b1;
        end else begin
          // copy one byte at a time so an overlapping source sees fresh bytes
          for (int k = 0; k < len; k++) begin
            put_byte(dict[src]);
            src = src + 12'd1;
          end
          advance_flag();
        end
      end
    endcase
    if (fin && !ended) begin
      queue_word('{8'h00, ST_RAN_OUT, 1'b0});
      ended = 1'b1;
    end
    if (step_words.size() > 0) begin
      step_words[step_words.size() - 1].last = 1'b1;
    end
    expected_words = {expected_words, step_words};
  endtask

  always @(posedge clk) begin
    lz_word_t got;
    lz_word_t want;
    if (!rst_n) begin
      limit = '1;
      restart_decoder();
      expected_words.delete();
      err_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) limit = cfg_data;
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        got = '{out_tdata, out_tuser, out_tlast};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got data=%02h status=%0d last=%0b",
                   $time, got.data, got.status, got.last);
          err_count++;
        end else begin
          want = expected_words.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected data=%02h status=%0d last=%0b,",
                     $time, want.data, want.status, want.last,
                     " got data=%02h status=%0d last=%0b",
                     got.data, got.status, got.last);
            err_count++;
          end
        end
      end
    end
    pending <= expected_words.size();
    fails   <= err_count;
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the compressed RTF decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import lzfu_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] compressed_byte
  logic        in_tuser;   // [0] start_of_message
  logic        in_tlast;   // final_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic [1:0]  out_tuser;  // [1:0] status
  logic        out_tlast;  // last
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  int          fails;
  int          pending;

  bit          calm;
  bit          long_hold;
  logic [7:0]  msg_bytes [$];

  compressed_rtf_lz_decoder_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  lzfu_stream_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fails      (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("compressed_rtf_lz_decoder_core test failed");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold && !hold_done) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic sos, input logic fin);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= sos;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid, let every expected word arrive, then allow the block to settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build a well-formed payload of n_tok tokens, optionally closed by an end token.
  task automatic build_msg(input int n_tok, input bit with_end);
    logic [7:0]  ctrl;
    logic [11:0] wp;
    logic [11:0] src;
    logic [3:0]  ln;
    int          left;
    int          grp;
    msg_bytes.delete();
    wp   = 12'(PRE_LEN);
    left = n_tok + (with_end ? 1 : 0);
    while (left > 0) begin
      grp  = (left > 8) ? 8 : left;
      ctrl = 8'($urandom);
      if (with_end && left <= 8) ctrl[left-1] = 1'b1;
      msg_bytes.push_back(ctrl);
      for (int i = 0; i < grp; i++) begin
        if (ctrl[i]) begin
          ln = 4'($urandom);
          if (with_end && left == 1) begin
            src = wp;
          end else begin
            case ($urandom_range(0, 2))
              0: src = wp - 12'($urandom_range(1, 40));
              1: src = 12'($urandom_range(0, PRE_LEN - 1));
              default: src = 12'($urandom);
            endcase
            if (src == wp) src = src + 12'd1;
          end
          msg_bytes.push_back(src[11:4]);
          msg_bytes.push_back({src[3:0], ln});
          wp = wp + 12'(ln) + 12'd2;
        end else begin
          msg_bytes.push_back(8'($urandom));
          wp = wp + 12'd1;
        end
        left--;
      end
    end
  endtask

  initial begin
    int          sent;
    int          cut;
    int          pick;
    bit          fin;
    logic [31:0] limits [5];

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= 32'h0;
    calm      = 1'b0;
    long_hold = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_limit(32'hFFFF_FFFF);
    // literal extremes, full-length preamble copy, overlapping copy, end token
    send_word(8'h06, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h0F, 1'b0, 1'b0);
    send_word(8'h0E, 1'b0, 1'b0);
    send_word(8'h03, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h55, 1'b0, 1'b0);
    send_word(8'hAA, 1'b0, 1'b0);
    send_word(8'h80, 1'b0, 1'b0);
    send_word(8'h01, 1'b0, 1'b0);
    send_word(8'h01, 1'b0, 1'b0);
    send_word(8'h0E, 1'b0, 1'b0);
    send_word(8'hB0, 1'b0, 1'b0);
    send_word(8'h44, 1'b0, 1'b1);
    // offset wrap past the top of the dictionary, then input runs out
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'hF4, 1'b0, 1'b0);
    send_word(8'h9C, 1'b0, 1'b1);
    // input runs out right on a control byte
    send_word(8'h00, 1'b1, 1'b1);
    drain();

    write_limit(32'd1);
    // a reference past the limit, then a literal past it
    send_word(8'h02, 1'b1, 1'b0);
    send_word(8'h12, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h10, 1'b0, 1'b0);
    send_word(8'h33, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h7E, 1'b0, 1'b0);
    send_word(8'h7F, 1'b0, 1'b0);
    drain();

    limits[0] = 32'($urandom_range(10, 80));
    limits[1] = 32'hFFFF_FFFF;
    limits[2] = 32'hFFFF_FFFE;
    limits[3] = $urandom | 32'h8000_0000;
    limits[4] = 32'hFFFF_FFFF;
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      calm = (ph == 4);
      if (ph == 1) long_hold = 1'b1;
      sent = 0;
      while (sent < 20) begin
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
          // noise that starts a fresh message
          for (int i = 0; i < 6; i++) begin
            send_word(8'($urandom), i == 0 || $urandom_range(0, 7) == 0,
                      $urandom_range(0, 15) == 0);
          end
          sent += 6;
        end else begin
          build_msg($urandom_range(1, 12), pick < 6);
          cut = msg_bytes.size();
          if (pick == 8) cut = $urandom_range(1, msg_bytes.size());
          if (pick < 6) fin = $urandom_range(0, 1);
          else fin = (pick != 7);
          for (int i = 0; i < cut; i++) begin
            send_word(msg_bytes[i], i == 0, fin && i == cut - 1);
          end
          sent += cut;
          // bytes after an end must be dropped
          if (pick < 2) begin
            repeat (2) send_word(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
          end
        end
      end
      drain();
    end

    if (fails == 0) begin
      $display("compressed_rtf_lz_decoder_core test passed");
    end else begin
      $display("compressed_rtf_lz_decoder_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lzfu_pkg.sv
hw/rtl/lzfu_ram.sv
hw/rtl/lzfu_dict.sv
hw/rtl/compressed_rtf_lz_decoder_core.sv
test/lzfu_stream_checker.sv
test/tb.sv
